[rtl/bba_pkg.sv]
// Shared types and constants of the bitmap block allocator.
package bba_pkg;

   // Data path widths.
   localparam int ADDR_W       = 32;
   localparam int DIV_W        = 33;
   localparam int HEADER_BYTES = 4;

   // The used map is stored as words of this many block bits.
   localparam int WORD_BITS  = 8;
   localparam int WORD_SEL_W = 3;

   // Default geometry of the managed region.
   localparam int NUM_BLOCKS_DEFAULT  = 4096;
   localparam int BLOCK_BYTES_DEFAULT = 1024;

   // Request action codes.
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   // Response status codes.
   typedef enum logic [2:0] {
      STAT_OK      = 3'd0,
      STAT_ZERO    = 3'd1,
      STAT_NOSPACE = 3'd2,
      STAT_NULL    = 3'd3,
      STAT_RANGE   = 3'd4
   } status_type;

   // Sequencer states.
   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DIV,
      S_SCAN,
      S_MUL,
      S_ADDR,
      S_LEN,
      S_FREE,
      S_RMW_RD,
      S_RMW_WR,
      S_RESP
   } state_type;

endpackage

[rtl/bba_div.sv]
// Division by a power-of-two block size: a shift and a mask, registered.
module bba_div #(
   parameter int DIV_W   = bba_pkg::DIV_W,
   parameter int DIVISOR = bba_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DIV_W-1:0] dividend,
   output logic             done,
   output logic [DIV_W-1:0] quotient,
   output logic [$clog2(DIVISOR+1)-1:0] remainder
);

   localparam int DVS_W = $clog2(DIVISOR + 1);
   localparam int SHIFT = $clog2(DIVISOR);

   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic             done_ff, done_in;

   // The block size is a power of two, so the quotient is a shift and the
   // remainder the low bits; both are ready the cycle after start.
   always_comb begin
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      done_in = start;
      if (start) begin
         quo_in = dividend >> SHIFT;
         rem_in = DVS_W'(dividend & DIV_W'(DIVISOR - 1));
      end
   end

   // Only the done flag is reset; the data registers are loaded at start.
   always_ff @(posedge clock) begin
      if (reset) begin
         done_ff <= 1'b0;
      end else begin
         done_ff <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done      = done_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

[rtl/bba_scan.sv]
// Free-run counter over one map word, scanned from its top bit downward.
module bba_scan #(
   parameter int CNT_W = 13
) (
   input  logic [bba_pkg::WORD_BITS-1:0]  word_used,
   input  logic [CNT_W-1:0]               cnt_in,
   input  logic [CNT_W-1:0]               need,
   output logic                           found,
   output logic [bba_pkg::WORD_SEL_W-1:0] hit_bit,
   output logic [CNT_W-1:0]               cnt_out
);

   logic [CNT_W-1:0] cnt;

   // A used bit restarts the run; the first bit that completes the run wins.
   always_comb begin
      cnt     = cnt_in;
      found   = 1'b0;
      hit_bit = '0;
      for (int j = bba_pkg::WORD_BITS - 1; j >= 0; j--) begin
         if (!found) begin
            if (word_used[j]) begin
               cnt = '0;
            end else begin
               cnt = cnt + CNT_W'(1);
               if (cnt == need) begin
                  found   = 1'b1;
                  hit_bit = bba_pkg::WORD_SEL_W'(j);
               end
            end
         end
      end
      cnt_out = cnt;
   end

endmodule

[rtl/bitmap_block_allocator_unit.sv]
// Top level of the bitmap block allocator: sequencer, used map and run length store.
//
// Requests arrive on the req_ channel (valid/stall): req_action selects allocate or
// free, req_size_bytes is the byte count of an allocate, req_address the address of
// a free. Each request yields exactly one response on the rsp_ channel with the
// address after the header and a status. csr_ writes set the region base address;
// they are always taken. BLOCK_BYTES must be a power of two.
// One request is in work at a time; req_stall is high from acceptance until the
// response has been placed in the output register. An allocate runs the divider,
// the one-word-per-cycle map scan from the top (at most NUM_WORDS = NUM_BLOCKS / 8
// words, rounded up, 512 by default) and the read-modify-write marking of the run;
// one that finds no run ends after the scan. A free reads the stored run length and
// clears the run. A run too long or a bad free address is decided after the divider,
// a zero size or a null free already in idle. The next request can be taken in the
// cycle after the response is loaded. After reset the block runs a clearing pass
// over the used map, one word a cycle, and holds req_stall high meanwhile. A stalled
// response stays in the output register; the next request may already be accepted
// and waits for the register to free before its own response is loaded.
module bitmap_block_allocator_unit #(
   parameter int NUM_BLOCKS  = bba_pkg::NUM_BLOCKS_DEFAULT,
   parameter int BLOCK_BYTES = bba_pkg::BLOCK_BYTES_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_action,
   input  logic [31:0] req_size_bytes,
   input  logic [31:0] req_address,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_result_address,
   output logic [2:0]  rsp_status,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [31:0] csr_base_address
);

   localparam int WB        = bba_pkg::WORD_BITS;
   localparam int SEL_W     = bba_pkg::WORD_SEL_W;
   localparam int DIV_W     = bba_pkg::DIV_W;
   localparam int NUM_WORDS = (NUM_BLOCKS + WB - 1) / WB;
   localparam int WRD_W     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
   localparam int MEM_WORDS = 2 ** WRD_W;
   localparam int BLK_W     = WRD_W + SEL_W;
   localparam int RUN_DEPTH = 2 ** BLK_W;
   localparam int CNT_W     = $clog2(NUM_BLOCKS + 1);
   localparam int SUM_W     = ((BLK_W > CNT_W) ? BLK_W : CNT_W) + 1;
   localparam int BB_W      = $clog2(BLOCK_BYTES + 1);
   localparam int PROD_W    = BLK_W + BB_W;
   localparam int REM_W     = $clog2(BLOCK_BYTES + 1);

   // Sequencer and data path registers.
   bba_pkg::state_type  state_ff, state_in;
   bba_pkg::status_type res_status_ff, res_status_in;
   bba_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0]         base_ff, base_in;
   logic                action_ff, action_in;
   logic [CNT_W-1:0]    n_ff, n_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [WRD_W-1:0]    scan_ptr_ff, scan_ptr_in;
   logic [WRD_W-1:0]    eval_ptr_ff, eval_ptr_in;
   logic                rd_pend_ff, rd_pend_in;
   logic [BLK_W-1:0]    blk_ff, blk_in;
   logic [BLK_W-1:0]    lo_ff, lo_in;
   logic [BLK_W-1:0]    hi_ff, hi_in;
   logic [WRD_W-1:0]    wptr_ff, wptr_in;
   logic                set_ff, set_in;
   logic [WRD_W-1:0]    clr_ptr_ff, clr_ptr_in;
   logic [PROD_W-1:0]   prod_ff, prod_in;
   logic [31:0]         res_addr_ff, res_addr_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [31:0]         rsp_addr_ff, rsp_addr_in;

   // Memory ports.
   logic [WB-1:0]    used_mem [MEM_WORDS];
   logic [WB-1:0]    used_rdata_ff;
   logic [WRD_W-1:0] used_raddr;
   logic             used_we;
   logic [WRD_W-1:0] used_waddr;
   logic [WB-1:0]    used_wdata;
   logic [CNT_W-1:0] run_mem [RUN_DEPTH];
   logic [CNT_W-1:0] run_rdata_ff;
   logic             run_we;
   logic [BLK_W-1:0] run_waddr;

   // Divider and scan connections.
   logic             div_start;
   logic [DIV_W-1:0] div_dividend;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [REM_W-1:0] div_rem;
   logic [WB-1:0]    pad_mask;
   logic [WB-1:0]    rmw_mask;
   logic             sc_found;
   logic [SEL_W-1:0] sc_bit;
   logic [CNT_W-1:0] sc_cnt;

   // Working values of the sequencer.
   logic [DIV_W-1:0] alloc_dvd;
   logic [31:0]      free_off;
   logic [BLK_W-1:0] found_blk;
   logic [SUM_W-1:0] hi_sum;
   logic [SUM_W-1:0] end_sum;
   logic [SUM_W-1:0] end_clip;

   // Shared divider for the block count of an allocate and the offset of a free.
   bba_div #(
      .DIV_W   (DIV_W),
      .DIVISOR (BLOCK_BYTES)
   ) u_bba_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .dividend  (div_dividend),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // Run counter over the map word that arrived from memory.
   bba_scan #(
      .CNT_W (CNT_W)
   ) u_bba_scan (
      .word_used (used_rdata_ff | pad_mask),
      .cnt_in    (count_ff),
      .need      (n_ff),
      .found     (sc_found),
      .hit_bit   (sc_bit),
      .cnt_out   (sc_cnt)
   );

   // Blocks past the end of the region look used to the scan.
   always_comb begin
      for (int j = 0; j < WB; j++) begin
         pad_mask[j] = (SUM_W'({eval_ptr_ff, SEL_W'(j)}) >= SUM_W'(NUM_BLOCKS));
      end
   end

   // Bits of the current word that lie inside the run being marked or cleared.
   always_comb begin
      for (int j = 0; j < WB; j++) begin
         rmw_mask[j] = ({wptr_ff, SEL_W'(j)} >= lo_ff) && ({wptr_ff, SEL_W'(j)} <= hi_ff);
      end
   end

   assign alloc_dvd = {1'b0, req_size_bytes}
                      + DIV_W'(bba_pkg::HEADER_BYTES + BLOCK_BYTES - 1);
   assign free_off  = req_address - 32'(bba_pkg::HEADER_BYTES) - base_ff;
   assign found_blk = {eval_ptr_ff, sc_bit};
   assign hi_sum    = SUM_W'(found_blk) + SUM_W'(n_ff) - SUM_W'(1);
   assign end_sum   = SUM_W'(blk_ff) + SUM_W'(run_rdata_ff);
   assign end_clip  = (end_sum > SUM_W'(NUM_BLOCKS)) ? SUM_W'(NUM_BLOCKS) : end_sum;

   // Next state and outputs of the sequencer.
   always_comb begin
      state_in      = state_ff;
      res_status_in = res_status_ff;
      rsp_status_in = rsp_status_ff;
      base_in       = base_ff;
      action_in     = action_ff;
      n_in          = n_ff;
      count_in      = count_ff;
      scan_ptr_in   = scan_ptr_ff;
      eval_ptr_in   = eval_ptr_ff;
      rd_pend_in    = rd_pend_ff;
      blk_in        = blk_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      wptr_in       = wptr_ff;
      set_in        = set_ff;
      clr_ptr_in    = clr_ptr_ff;
      prod_in       = prod_ff;
      res_addr_in   = res_addr_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      used_raddr    = scan_ptr_ff;
      used_we       = 1'b0;
      used_waddr    = wptr_ff;
      used_wdata    = used_rdata_ff;
      run_we        = 1'b0;
      run_waddr     = found_blk;
      div_start     = 1'b0;
      div_dividend  = alloc_dvd;

      // Register writes are taken in every state.
      if (csr_valid) begin
         base_in = csr_base_address;
      end

      unique case (state_ff)
         // Zero the used map after reset, one word a cycle.
         bba_pkg::S_CLEAR: begin
            used_we    = 1'b1;
            used_waddr = clr_ptr_ff;
            used_wdata = '0;
            clr_ptr_in = clr_ptr_ff + WRD_W'(1);
            if (clr_ptr_ff == WRD_W'(NUM_WORDS - 1)) begin
               state_in = bba_pkg::S_IDLE;
            end
         end

         // Take a request and start the divider, or finish the trivial cases.
         bba_pkg::S_IDLE: begin
            if (req_valid) begin
               action_in   = req_action;
               res_addr_in = '0;
               if (req_action == bba_pkg::ACT_ALLOC) begin
                  if (req_size_bytes == '0) begin
                     res_status_in = bba_pkg::STAT_ZERO;
                     state_in      = bba_pkg::S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = bba_pkg::S_DIV;
                  end
               end else begin
                  div_dividend = {1'b0, free_off};
                  if (req_address == '0) begin
                     res_status_in = bba_pkg::STAT_NULL;
                     state_in      = bba_pkg::S_RESP;
                  end else begin
                     div_start = 1'b1;
                     state_in  = bba_pkg::S_DIV;
                  end
               end
            end
         end

         // Check the quotient: run length for allocate, start block for free.
         bba_pkg::S_DIV: begin
            if (div_done) begin
               if (action_ff == bba_pkg::ACT_ALLOC) begin
                  if (div_quo > DIV_W'(NUM_BLOCKS)) begin
                     res_status_in = bba_pkg::STAT_NOSPACE;
                     state_in      = bba_pkg::S_RESP;
                  end else begin
                     n_in        = div_quo[CNT_W-1:0];
                     count_in    = '0;
                     scan_ptr_in = WRD_W'(NUM_WORDS - 1);
                     rd_pend_in  = 1'b0;
                     state_in    = bba_pkg::S_SCAN;
                  end
               end else begin
                  if (div_rem != '0 || div_quo >= DIV_W'(NUM_BLOCKS)) begin
                     res_status_in = bba_pkg::STAT_RANGE;
                     state_in      = bba_pkg::S_RESP;
                  end else begin
                     blk_in   = div_quo[BLK_W-1:0];
                     state_in = bba_pkg::S_LEN;
                  end
               end
            end
         end

         // Stream map words from the top down and count the free run.
         bba_pkg::S_SCAN: begin
            used_raddr  = scan_ptr_ff;
            scan_ptr_in = scan_ptr_ff - WRD_W'(1);
            eval_ptr_in = scan_ptr_ff;
            rd_pend_in  = 1'b1;
            if (rd_pend_ff) begin
               count_in = sc_cnt;
               if (sc_found) begin
                  run_we     = 1'b1;
                  run_waddr  = found_blk;
                  blk_in     = found_blk;
                  lo_in      = found_blk;
                  hi_in      = hi_sum[BLK_W-1:0];
                  wptr_in    = eval_ptr_ff;
                  set_in     = 1'b1;
                  rd_pend_in = 1'b0;
                  state_in   = bba_pkg::S_MUL;
               end else if (eval_ptr_ff == '0) begin
                  res_status_in = bba_pkg::STAT_NOSPACE;
                  rd_pend_in    = 1'b0;
                  state_in      = bba_pkg::S_RESP;
               end
            end
         end

         // Byte offset of the start block.
         bba_pkg::S_MUL: begin
            prod_in  = PROD_W'(blk_ff) * PROD_W'(BLOCK_BYTES);
            state_in = bba_pkg::S_ADDR;
         end

         // Address after the header, then mark the run used.
         bba_pkg::S_ADDR: begin
            res_addr_in   = base_ff + 32'(prod_ff) + 32'(bba_pkg::HEADER_BYTES);
            res_status_in = bba_pkg::STAT_OK;
            state_in      = bba_pkg::S_RMW_RD;
         end

         // Wait for the stored run length of the start block.
         bba_pkg::S_LEN: begin
            state_in = bba_pkg::S_FREE;
         end

         // Clear from the start block up to the recorded length or the map end.
         bba_pkg::S_FREE: begin
            res_status_in = bba_pkg::STAT_OK;
            if (run_rdata_ff == '0) begin
               state_in = bba_pkg::S_RESP;
            end else begin
               lo_in    = blk_ff;
               hi_in    = BLK_W'(end_clip - SUM_W'(1));
               wptr_in  = blk_ff[BLK_W-1 -: WRD_W];
               set_in   = 1'b0;
               state_in = bba_pkg::S_RMW_RD;
            end
         end

         // Read one map word of the run.
         bba_pkg::S_RMW_RD: begin
            used_raddr = wptr_ff;
            state_in   = bba_pkg::S_RMW_WR;
         end

         // Write it back with the run's bits set or cleared.
         bba_pkg::S_RMW_WR: begin
            used_we    = 1'b1;
            used_waddr = wptr_ff;
            used_wdata = set_ff ? (used_rdata_ff | rmw_mask) : (used_rdata_ff & ~rmw_mask);
            if (wptr_ff == hi_ff[BLK_W-1 -: WRD_W]) begin
               state_in = bba_pkg::S_RESP;
            end else begin
               wptr_in  = wptr_ff + WRD_W'(1);
               state_in = bba_pkg::S_RMW_RD;
            end
         end

         // Hand the result to the output register once it is free.
         bba_pkg::S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = res_addr_ff;
               rsp_status_in = res_status_ff;
               state_in      = bba_pkg::S_IDLE;
            end
         end

         default: begin
            state_in = bba_pkg::S_IDLE;
         end
      endcase
   end

   // Sequencer registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bba_pkg::S_CLEAR;
         clr_ptr_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         base_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         clr_ptr_ff   <= clr_ptr_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         base_ff      <= base_in;
      end
      res_status_ff <= res_status_in;
      rsp_status_ff <= rsp_status_in;
      action_ff     <= action_in;
      n_ff          <= n_in;
      count_ff      <= count_in;
      scan_ptr_ff   <= scan_ptr_in;
      eval_ptr_ff   <= eval_ptr_in;
      blk_ff        <= blk_in;
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      wptr_ff       <= wptr_in;
      set_ff        <= set_in;
      prod_ff       <= prod_in;
      res_addr_ff   <= res_addr_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   // Used map: one write and one registered read per cycle.
   always_ff @(posedge clock) begin
      if (used_we) begin
         used_mem[used_waddr] <= used_wdata;
      end
      used_rdata_ff <= used_mem[used_raddr];
   end

   // Run lengths, recorded at each run's start block.
   always_ff @(posedge clock) begin
      if (run_we) begin
         run_mem[run_waddr] <= n_ff;
      end
      run_rdata_ff <= run_mem[blk_ff];
   end

   assign req_stall          = (state_ff != bba_pkg::S_IDLE);
   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_status         = rsp_status_ff;
   assign csr_ready          = 1'b1;

endmodule

[rtl/bba_checker.sv]
// Port-level checks of the bitmap block allocator and their binding.
module bba_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [31:0] rsp_result_address,
   input logic [2:0]  rsp_status
);

   // A stalled response holds its value.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_address)
                                 && $stable(rsp_status))
      else $error("stalled response changed");

   // Failed requests return no address.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != bba_pkg::STAT_OK |-> rsp_result_address == '0)
      else $error("error response carries an address");

   // The block works on one request at a time.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while another is in work");

   // No response is pending in the first cycle out of reset.
   assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bitmap_block_allocator_unit bba_checker u_bba_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_stall          (req_stall),
   .rsp_valid          (rsp_valid),
   .rsp_stall          (rsp_stall),
   .rsp_result_address (rsp_result_address),
   .rsp_status         (rsp_status)
);

[tb/sv/tb_top.sv]
// Self-checking testbench for the bitmap block allocator unit.
module tb_top;
   import bba_pkg::*;

   localparam int NUM_BLK  = NUM_BLOCKS_DEFAULT;
   localparam int BLOCK_SZ = BLOCK_BYTES_DEFAULT;
   localparam longint TIMEOUT_CYCLES = 12_000_000;

   // One response of the allocator: address after the header and a status.
   typedef struct packed {
      logic [31:0] addr;
      status_type  status;
   } alloc_response_type;

   // Mirror of the used map and run lengths, plus the queue of responses still owed.
   class alloc_scoreboard;
      bit                 used_map[NUM_BLK];
      int unsigned        run_len[NUM_BLK];
      bit                 len_known[NUM_BLK];
      logic [31:0]        base_addr = '0;
      alloc_response_type pending_results[$];
      int unsigned        checked = 0;
      int unsigned        mismatches = 0;
      int unsigned        status_seen[5];
      int                 last_block = -1;

      // Works out the response to an accepted request and updates the mirror.
      function alloc_response_type note_request(logic act, logic [31:0] size,
                                                logic [31:0] addr);
         alloc_response_type rsp;
         longint unsigned nblk;
         int unsigned     run_cnt;
         int unsigned     start;
         int unsigned     stop;
         int              b;
         int              k;
         logic [31:0]     off;
         rsp.addr   = '0;
         rsp.status = STAT_OK;
         last_block = -1;
         if (act == ACT_ALLOC) begin
            if (size == 32'd0) begin
               rsp.status = STAT_ZERO;
            end else begin
               nblk = ({32'd0, size} + 64'(HEADER_BYTES + BLOCK_SZ - 1)) / BLOCK_SZ;
               rsp.status = STAT_NOSPACE;
               if (nblk <= NUM_BLK) begin
                  // Scan from the top block down for the highest free run.
                  run_cnt = 0;
                  for (b = NUM_BLK - 1; b >= 0; b--) begin
                     if (used_map[b]) begin
                        run_cnt = 0;
                     end else begin
                        run_cnt++;
                        if (run_cnt == nblk) begin
                           for (k = b; k < b + nblk; k++) used_map[k] = 1'b1;
                           run_len[b]   = nblk;
                           len_known[b] = 1'b1;
                           rsp.addr     = base_addr + b * BLOCK_SZ + HEADER_BYTES;
                           rsp.status   = STAT_OK;
                           last_block   = b;
                           break;
                        end
                     end
                  end
               end
            end
         end else if (addr == 32'd0) begin
            rsp.status = STAT_NULL;
         end else begin
            off = addr - HEADER_BYTES - base_addr;
            if ((off % BLOCK_SZ) != 0 || off >= NUM_BLK * BLOCK_SZ) begin
               rsp.status = STAT_RANGE;
            end else begin
               // Clear the stored count of blocks, stopping at the end of the map.
               start = off / BLOCK_SZ;
               stop  = start + run_len[start];
               if (stop > NUM_BLK) stop = NUM_BLK;
               for (k = start; k < stop; k++) used_map[k] = 1'b0;
            end
         end
         pending_results.push_back(rsp);
         status_seen[rsp.status]++;
         return rsp;
      endfunction

      // A free must never land on a start block whose run length was never recorded.
      function bit can_free(logic [31:0] addr);
         logic [31:0] off;
         off = addr - HEADER_BYTES - base_addr;
         if (addr == 32'd0 || (off % BLOCK_SZ) != 0 || off >= NUM_BLK * BLOCK_SZ) return 1'b1;
         return len_known[off / BLOCK_SZ];
      endfunction

      // Compares one accepted response with the oldest expected one.
      function void check_response(logic [31:0] addr, status_type status);
         alloc_response_type exp_rsp;
         if (pending_results.size() == 0) begin
            mismatches++;
            $display("%0t: response with none expected: address %h, status %0d",
                     $time, addr, status);
            return;
         end
         exp_rsp = pending_results.pop_front();
         checked++;
         if (exp_rsp.addr !== addr) begin
            mismatches++;
            $display("%0t: result_address mismatch: expected %h, actual %h",
                     $time, exp_rsp.addr, addr);
         end
         if (exp_rsp.status !== status) begin
            mismatches++;
            $display("%0t: status mismatch: expected %0d, actual %0d",
                     $time, exp_rsp.status, status);
         end
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic        req_action;
   logic [31:0] req_size_bytes;
   logic [31:0] req_address;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_result_address;
   logic [2:0]  rsp_status;
   logic        csr_valid;
   logic        csr_ready;
   logic [31:0] csr_base_address;

   alloc_scoreboard sb = new();
   int live_blocks[$];
   int req_gap_pct  = 0;
   int rsp_hold_pct = 0;

   bitmap_block_allocator_unit u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_action         (req_action),
      .req_size_bytes     (req_size_bytes),
      .req_address        (req_address),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_result_address (rsp_result_address),
      .rsp_status         (rsp_status),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_base_address   (csr_base_address)
   );

   // Free-running clock with a period of 10.
   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // The response side stalls at random, at the rate of the current phase.
   always @(negedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_hold_pct);
   end

   // Every accepted response is checked against the oldest expectation.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         sb.check_response(rsp_result_address, status_type'(rsp_status));
   end

   // Address of the first byte after the header of a block.
   function automatic logic [31:0] block_address(int blk);
      return sb.base_addr + blk * BLOCK_SZ + HEADER_BYTES;
   endfunction

   // Presents one request, with random gaps before it, and notes it once accepted.
   task automatic issue_request(input logic act, input logic [31:0] size,
                                input logic [31:0] addr);
      alloc_response_type rsp;
      @(negedge clock);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      // Steer a free away from a start block that never held a run length.
      if (act == ACT_FREE && !sb.can_free(addr)) addr = addr ^ 32'd1;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_size_bytes <= size;
      req_address    <= addr;
      do @(posedge clock); while (req_stall !== 1'b0);
      rsp = sb.note_request(act, size, addr);
      if (act == ACT_ALLOC && rsp.status == STAT_OK) live_blocks.push_back(sb.last_block);
   endtask

   // Stops sending and waits until every expected response has come back.
   task automatic wait_all_responses();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   // Writes the base address register and waits for csr_ready.
   task automatic write_base_address(input logic [31:0] value);
      @(negedge clock);
      csr_valid        <= 1'b1;
      csr_base_address <= value;
      do @(posedge clock); while (csr_ready !== 1'b1);
      sb.base_addr = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Mostly allocate/free pairs over live runs, with a share of malformed requests.
   task automatic run_random(input int count);
      int unsigned sel;
      int unsigned pct;
      int          idx;
      int          blk;
      logic [31:0] size;
      logic [31:0] addr;
      for (int i = 0; i < count; i++) begin
         sel  = $urandom_range(99);
         size = $urandom;
         addr = $urandom;
         if (sel < 45 && live_blocks.size() > 200) sel = 60;
         if (sel >= 45 && sel < 85 && live_blocks.size() == 0) sel = 0;
         if (sel < 45) begin
            // Small sizes dominate so that marking stays short.
            pct = $urandom_range(99);
            if (pct < 70) size = $urandom_range(3 * BLOCK_SZ, 1);
            else if (pct < 92) size = $urandom_range(16 * BLOCK_SZ, 1);
            else if (pct < 98) size = $urandom_range(256 * BLOCK_SZ, 1);
            issue_request(ACT_ALLOC, size, addr);
         end else if (sel < 85) begin
            // Free a live run; sometimes keep it listed so it gets freed again.
            idx = $urandom_range(live_blocks.size() - 1);
            blk = live_blocks[idx];
            if ($urandom_range(99) < 85) live_blocks.delete(idx);
            issue_request(ACT_FREE, size, block_address(blk));
         end else begin
            case ($urandom_range(5))
               0: issue_request(ACT_ALLOC, 32'd0, addr);
               1: issue_request(ACT_FREE, size, 32'd0);
               2: issue_request(ACT_FREE, size, addr);
               3: issue_request(ACT_FREE, size, block_address($urandom_range(NUM_BLK - 1)));
               4: issue_request(ACT_FREE, size, block_address($urandom_range(NUM_BLK - 1))
                                + $urandom_range(BLOCK_SZ - 1, 1));
               default: issue_request(ACT_ALLOC, 32'hFFFF_FFFF - $urandom_range(3), addr);
            endcase
         end
      end
   endtask

   // Main sequence: reset, directed requests, then random phases over several bases.
   initial begin
      logic [31:0] phase_base;
      req_valid        = 1'b0;
      req_action       = ACT_ALLOC;
      req_size_bytes   = '0;
      req_address      = '0;
      csr_valid        = 1'b0;
      csr_base_address = '0;
      rsp_stall        = 1'b0;
      reset            = 1'b1;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      req_gap_pct  = 19;
      rsp_hold_pct = 72;
      write_base_address(32'h4000_0000);

      // Directed part: size extremes, whole-map run at block zero, bad frees, holes.
      issue_request(ACT_ALLOC, 32'd0, 32'hFFFF_FFFF);
      issue_request(ACT_FREE, 32'hFFFF_FFFF, 32'd0);
      issue_request(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
      issue_request(ACT_ALLOC, NUM_BLK * BLOCK_SZ - HEADER_BYTES + 1, 32'd0);
      issue_request(ACT_ALLOC, NUM_BLK * BLOCK_SZ - HEADER_BYTES, 32'd0);
      issue_request(ACT_ALLOC, 32'd1, 32'd0);
      issue_request(ACT_FREE, 32'd0, block_address(0));
      issue_request(ACT_FREE, 32'd0, block_address(0) + 1);
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK));
      issue_request(ACT_FREE, 32'd0, 32'hFFFF_FFFF);
      issue_request(ACT_ALLOC, 32'd1, 32'd0);
      issue_request(ACT_ALLOC, BLOCK_SZ - HEADER_BYTES, 32'd0);
      issue_request(ACT_ALLOC, BLOCK_SZ - HEADER_BYTES + 1, 32'd0);
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 2));
      issue_request(ACT_ALLOC, 32'd2000, 32'd0);
      issue_request(ACT_ALLOC, 32'd1, 32'd0);
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 4));
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 4));
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 1));
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 6));
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 2));
      issue_request(ACT_ALLOC, 32'd3000, 32'd0);
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 1));
      issue_request(ACT_FREE, 32'd0, block_address(NUM_BLK - 3));
      wait_all_responses();
      live_blocks.delete();

      // Random phases; idle profile changes every two phases.
      for (int phase = 0; phase < 6; phase++) begin
         req_gap_pct  = (phase < 2) ? 19 : (phase < 4) ? 72 : 0;
         rsp_hold_pct = (phase < 2) ? 72 : (phase < 4) ? 19 : 0;
         case (phase)
            0:       phase_base = 32'hFFFF_FFFF;
            2:       phase_base = 32'hFFFF_FFFC;
            3:       phase_base = 32'h8000_0000;
            5:       phase_base = 32'h0000_0000;
            default: phase_base = $urandom;
         endcase
         write_base_address(phase_base);
         if (phase == 0) begin
            run_random(80);
            wait_all_responses();
            run_random(83);
         end else begin
            run_random(163);
         end
         wait_all_responses();
      end

      // Let any late or stray response show up before the verdict.
      repeat (100) @(posedge clock);
      $display("Checked %0d responses: ok %0d, zero size %0d, no space %0d, null %0d, range %0d.",
               sb.checked, sb.status_seen[STAT_OK], sb.status_seen[STAT_ZERO],
               sb.status_seen[STAT_NOSPACE], sb.status_seen[STAT_NULL],
               sb.status_seen[STAT_RANGE]);
      $display("Seven base address settings, three idle profiles, %0d mismatches.",
               sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog against a hung handshake.
   initial begin
      #(TIMEOUT_CYCLES * 10);
      $display("FAILED: results differ");
      $finish;
   end

endmodule

[sim.f]
rtl/bba_pkg.sv
rtl/bba_div.sv
rtl/bba_scan.sv
rtl/bitmap_block_allocator_unit.sv
rtl/bba_checker.sv
tb/sv/tb_top.sv
